@@ rtl/rtti_pkg.sv @@
// ----------------------------------------------------------------------------
// rtti_pkg: shared types and constants
// Character codes, parse phases, register indexes and the queue item type
// used by the radix text to integer converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rtti_pkg;

  localparam int MAX_SYMBOLS_DEF = 16;   // largest alphabet the block supports
  localparam int SYM_W           = 8;    // one symbol is one byte
  localparam int DIGIT_W         = 4;    // digit value 0..15
  localparam int COUNT_W         = 5;    // digit_count register width
  localparam int SYMS_W          = 64;   // each symbol register holds 8 symbols
  localparam int VALUE_W         = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int QUEUE_DEPTH     = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_HI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

  // characters with a fixed meaning
  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
  localparam logic [SYM_W-1:0] CH_TAB   = 8'h09;
  localparam logic [SYM_W-1:0] CH_LF    = 8'h0a;
  localparam logic [SYM_W-1:0] CH_VT    = 8'h0b;
  localparam logic [SYM_W-1:0] CH_FF    = 8'h0c;
  localparam logic [SYM_W-1:0] CH_CR    = 8'h0d;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2d;

  localparam logic [COUNT_W-1:0] MIN_RADIX = 5'd2;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGIT,
    PH_DONE
  } phase_t;

  // one classified byte on its way from the front to the back
  typedef struct packed {
    logic               is_zero;
    logic               is_space;
    logic               is_plus;
    logic               is_minus;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic               eot;
    logic               base_ok;
  } rtti_item_t;

endpackage

`default_nettype wire

@@ rtl/rtti_if.sv @@
// ----------------------------------------------------------------------------
// rtti channels
// Valid/ready channels for text bytes in and parsed results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtti_in_if import rtti_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] text_byte;
  logic             end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface rtti_out_if import rtti_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      base_ok;

  modport source (output valid, output value, output base_ok, input ready);
  modport sink   (input valid, input value, input base_ok, output ready);
endinterface

`default_nettype wire

@@ rtl/rtti_front.sv @@
// ----------------------------------------------------------------------------
// rtti_front: input stage and byte classifier
// Registers each byte, matches it against the alphabet and pushes the
// classified item into the queue. Also keeps the registered alphabet check.
// ----------------------------------------------------------------------------
`default_nettype none

module rtti_front import rtti_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [SYM_W-1:0]   in_text_byte,
  input  wire logic               in_end_of_text,
  input  wire logic [SYMS_W-1:0]  sym_lo,
  input  wire logic [SYMS_W-1:0]  sym_hi,
  input  wire logic [COUNT_W-1:0] digit_count,
  input  wire logic               q_full,
  output logic                    q_push,
  output rtti_item_t              q_item
);

  localparam int SYMS_PER_REG = SYMS_W / SYM_W;

  logic             stg_vld_r, stg_vld_nxt;
  logic [SYM_W-1:0] stg_byte_r;
  logic             stg_eot_r;
  logic             base_ok_r, base_ok_nxt;
  logic [SYM_W-1:0] syms [2*SYMS_PER_REG];
  logic             accept;
  logic             hit;
  logic [DIGIT_W-1:0] hit_val;

  assign in_ready = !stg_vld_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = stg_vld_r && !q_full;

  always_comb begin
    for (int k = 0; k < SYMS_PER_REG; k++) begin
      syms[k]                = sym_lo[k*SYM_W +: SYM_W];
      syms[k + SYMS_PER_REG] = sym_hi[k*SYM_W +: SYM_W];
    end
  end

  // alphabet check: range of the count, forbidden symbols, duplicates
  always_comb begin
    base_ok_nxt = (digit_count >= MIN_RADIX) &&
                  (digit_count <= COUNT_W'(MAX_SYMBOLS));
    for (int a = 0; a < MAX_SYMBOLS; a++) begin
      if (COUNT_W'(a) < digit_count) begin
        if (syms[a] == CH_NUL || syms[a] == CH_PLUS ||
            syms[a] == CH_MINUS || syms[a] == CH_SPACE) begin
          base_ok_nxt = 1'b0;
        end
        for (int b = a + 1; b < MAX_SYMBOLS; b++) begin
          if (COUNT_W'(b) < digit_count && syms[b] == syms[a]) begin
            base_ok_nxt = 1'b0;
          end
        end
      end
    end
  end

  // lowest matching position wins
  always_comb begin
    hit     = 1'b0;
    hit_val = '0;
    for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
      if (COUNT_W'(k) < digit_count && syms[k] == stg_byte_r) begin
        hit     = 1'b1;
        hit_val = DIGIT_W'(k);
      end
    end
  end

  always_comb begin
    q_item.is_zero  = (stg_byte_r == CH_NUL);
    q_item.is_space = (stg_byte_r == CH_SPACE) || (stg_byte_r == CH_TAB) ||
                      (stg_byte_r == CH_LF) || (stg_byte_r == CH_VT) ||
                      (stg_byte_r == CH_FF) || (stg_byte_r == CH_CR);
    q_item.is_plus  = (stg_byte_r == CH_PLUS);
    q_item.is_minus = (stg_byte_r == CH_MINUS);
    q_item.is_digit = hit;
    q_item.digit    = hit_val;
    q_item.eot      = stg_eot_r;
    q_item.base_ok  = base_ok_r;
  end

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (accept) begin
      stg_vld_nxt = 1'b1;
    end else if (q_push) begin
      stg_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      base_ok_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      base_ok_r <= base_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_byte_r <= in_text_byte;
      stg_eot_r  <= in_end_of_text;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rtti_queue.sv @@
// ----------------------------------------------------------------------------
// rtti_queue: short item queue
// Small first-in first-out buffer between the classifier and the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module rtti_queue import rtti_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire rtti_item_t  push_item,
  input  wire logic        pop,
  output rtti_item_t       head_item,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rtti_item_t       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (cnt_r == '0);
  assign head_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rtti_back.sv @@
// ----------------------------------------------------------------------------
// rtti_back: parser and accumulator
// Walks the parse phases, applies the sign run, multiplies and adds each
// digit, and loads the output register at the end of a string.
// ----------------------------------------------------------------------------
`default_nettype none

module rtti_back import rtti_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [COUNT_W-1:0] digit_count,
  input  wire rtti_item_t         q_item,
  input  wire logic               q_empty,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                    out_base_ok
);

  phase_t               phase_r, phase_nxt;
  logic                 neg_r, neg_nxt;
  logic [VALUE_W-1:0]   acc_r, acc_nxt;
  logic                 ovld_r, ovld_nxt;
  logic [VALUE_W-1:0]   oval_r, oval_nxt;
  logic                 obase_r, obase_nxt;
  logic [VALUE_W-1:0]   mac;
  phase_t               ph;
  logic                 neg;
  logic [VALUE_W-1:0]   acc;

  assign q_pop       = !q_empty && (!ovld_r || out_ready);
  assign mac         = acc_r * VALUE_W'(digit_count) + VALUE_W'(q_item.digit);
  assign out_valid   = ovld_r;
  assign out_value   = oval_r;
  assign out_base_ok = obase_r;

  always_comb begin
    ph        = phase_r;
    neg       = neg_r;
    acc       = acc_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    ovld_nxt  = ovld_r && !out_ready;
    oval_nxt  = oval_r;
    obase_nxt = obase_r;
    if (q_pop) begin
      if (q_item.is_zero) begin
        ph = PH_DONE;
      end
      if (ph == PH_SPACE && !q_item.is_space) begin
        ph = PH_SIGN;
      end
      if (ph == PH_SIGN) begin
        if (q_item.is_minus) begin
          neg = !neg;
        end else if (!q_item.is_plus) begin
          ph = PH_DIGIT;
        end
      end
      if (ph == PH_DIGIT) begin
        if (q_item.is_digit) begin
          acc = mac;
        end else begin
          ph = PH_DONE;
        end
      end
      if (q_item.eot) begin
        ovld_nxt  = 1'b1;
        obase_nxt = q_item.base_ok;
        oval_nxt  = !q_item.base_ok ? '0 : (neg ? ('0 - acc) : acc);
        phase_nxt = PH_SPACE;
        neg_nxt   = 1'b0;
        acc_nxt   = '0;
      end else begin
        phase_nxt = ph;
        neg_nxt   = neg;
        acc_nxt   = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oval_r  <= oval_nxt;
    obase_r <= obase_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/radix_text_to_integer_top.sv @@
// ----------------------------------------------------------------------------
// radix_text_to_integer_top: text to signed integer with a custom alphabet
// Parses a byte stream into a 32-bit integer using a configured digit set.
// ----------------------------------------------------------------------------
// Takes one text byte per item and emits one result (value, base_ok) on the
// item flagged end_of_text. Leading whitespace is skipped, a run of '+' and
// '-' sets the sign, digits from the configured alphabet accumulate with the
// alphabet size as radix (wrapping mod 2^32), and the first non-digit or a
// zero byte ends the number. An invalid alphabet gives value 0, base_ok 0.
// Throughput is one item per cycle while the output is not stalled: the input
// register, the classifier, a two-entry queue and the parser each take one
// item a cycle; the parser's single 32x5 multiply-add sets the critical path.
// Results pass the input register, queue and output register. The user must
// write configuration only while no string is in flight; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_text_to_integer_top import rtti_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  rtti_in_if.sink                   in_if,
  rtti_out_if.source                out_if,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SYMS_W-1:0]    cfg_wdata
);

  // alphabet registers
  logic [SYMS_W-1:0]  sym_lo_r;
  logic [SYMS_W-1:0]  sym_hi_r;
  logic [COUNT_W-1:0] digit_count_r;

  // queue between classifier and parser
  rtti_item_t push_item;
  rtti_item_t head_item;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;

  // register writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_lo_r      <= '0;
      sym_hi_r      <= '0;
      digit_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYM_LO: sym_lo_r      <= cfg_wdata;
        CFG_SYM_HI: sym_hi_r      <= cfg_wdata;
        CFG_COUNT:  digit_count_r <= cfg_wdata[COUNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // front: input register, byte classification, alphabet check
  rtti_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_text_byte  (in_if.text_byte),
    .in_end_of_text(in_if.end_of_text),
    .sym_lo        (sym_lo_r),
    .sym_hi        (sym_hi_r),
    .digit_count   (digit_count_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  // decouples the two halves so either side can stall alone
  rtti_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .pop      (q_pop),
    .head_item(head_item),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: parse phases, sign, multiply-add, output register
  rtti_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .digit_count(digit_count_r),
    .q_item     (head_item),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_value  (out_if.value),
    .out_base_ok(out_if.base_ok)
  );

endmodule

`default_nettype wire

@@ rtl/rtti_checker.sv @@
// ----------------------------------------------------------------------------
// rtti_checker: port-level assertions
// Watches the result channel of the converter over time.
// ----------------------------------------------------------------------------
`default_nettype none

module rtti_checker import rtti_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [VALUE_W-1:0] out_value,
  input wire logic                      out_base_ok
);

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // invalid alphabet always reports zero
  a_bad_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_base_ok |-> out_value == '0)
    else $error("nonzero value with invalid alphabet");

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind radix_text_to_integer_top rtti_checker u_rtti_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_value  (out_if.value),
  .out_base_ok(out_if.base_ok)
);

`default_nettype wire
